[src/rdc_pkg.sv]
package rdc_pkg;

    // default sizes for the top-level parameters
    localparam int DEFAULT_NUMBER_WIDTH = 32;
    localparam int DEFAULT_MAX_DIGITS   = 32;

    // field widths
    localparam int RADIX_W = 5;
    localparam int DIGIT_W = 4;

    // radix register bounds and reset value
    localparam logic [RADIX_W-1:0] RADIX_RESET = 5'd10;
    localparam logic [RADIX_W-1:0] RADIX_MIN   = 5'd2;
    localparam logic [RADIX_W-1:0] RADIX_MAX   = 5'd16;

    // long-division bits handled per cycle
    localparam int BITS_PER_CYCLE = 8;

    // back-end sequencer states
    typedef enum logic [1:0] {
        BK_IDLE,
        BK_DIV,
        BK_POP_RD,
        BK_POP_LOAD
    } back_state_t;

endpackage

[src/rdc_front.sv]
module rdc_front
    import rdc_pkg::*;
#(
    parameter int NUMBER_WIDTH = DEFAULT_NUMBER_WIDTH
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic [NUMBER_WIDTH-1:0] in_number,
    output logic                    item_valid,
    input  logic                    item_ready,
    output logic [NUMBER_WIDTH-1:0] item_number,
    output logic                    item_zero
);

    logic [NUMBER_WIDTH-1:0] number_q [2];
    logic                    zero_q   [2];
    logic                    wr_ptr_reg;
    logic                    wr_ptr_next;
    logic                    rd_ptr_reg;
    logic                    rd_ptr_next;
    logic [1:0]              fill_reg;
    logic [1:0]              fill_next;
    logic                    push;
    logic                    pop;

    // two-entry queue handshake
    assign in_ready   = (fill_reg != 2'd2);
    assign item_valid = (fill_reg != 2'd0);
    assign push       = in_valid && in_ready;
    assign pop        = item_valid && item_ready;

    assign item_number = number_q[rd_ptr_reg];
    assign item_zero   = zero_q[rd_ptr_reg];

    // pointer and fill bookkeeping
    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop  ? ~rd_ptr_reg : rd_ptr_reg;
        fill_next   = fill_reg;
        if (push && !pop)
        begin
            fill_next = fill_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            fill_next = fill_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    // store each beat with its zero classification
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            number_q[wr_ptr_reg] <= in_number;
            zero_q[wr_ptr_reg]   <= (in_number == '0);
        end
    end

endmodule

[src/rdc_back.sv]
module rdc_back
    import rdc_pkg::*;
#(
    parameter int NUMBER_WIDTH = DEFAULT_NUMBER_WIDTH,
    parameter int MAX_DIGITS   = DEFAULT_MAX_DIGITS
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic [RADIX_W-1:0]      radix,
    input  logic                    item_valid,
    output logic                    item_ready,
    input  logic [NUMBER_WIDTH-1:0] item_number,
    input  logic                    item_zero,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic [DIGIT_W-1:0]      out_digit,
    output logic                    out_last
);

    localparam int PAD_W   = ((NUMBER_WIDTH + BITS_PER_CYCLE - 1) / BITS_PER_CYCLE)
                             * BITS_PER_CYCLE;
    localparam int CHUNKS  = PAD_W / BITS_PER_CYCLE;
    localparam int CHUNK_W = (CHUNKS > 1) ? $clog2(CHUNKS) : 1;
    localparam int SP_W    = $clog2(MAX_DIGITS);
    localparam int CNT_W   = $clog2(MAX_DIGITS + 1);

    back_state_t                state_reg;
    back_state_t                state_next;
    logic [PAD_W-1:0]           work_reg;
    logic [PAD_W-1:0]           work_next;
    logic [DIGIT_W-1:0]         rem_reg;
    logic [DIGIT_W-1:0]         rem_next;
    logic [CHUNK_W-1:0]         chunk_reg;
    logic [CHUNK_W-1:0]         chunk_next;
    logic [CNT_W-1:0]           count_reg;
    logic [CNT_W-1:0]           count_next;
    logic                       out_valid_reg;
    logic                       out_valid_next;
    logic [DIGIT_W-1:0]         out_digit_reg;
    logic [DIGIT_W-1:0]         out_digit_next;
    logic                       out_last_reg;
    logic                       out_last_next;

    logic [DIGIT_W-1:0]         stack_mem [MAX_DIGITS];
    logic [DIGIT_W-1:0]         rd_data_reg;
    logic                       wr_en;
    logic [SP_W-1:0]            wr_addr;
    logic [DIGIT_W-1:0]         wr_data;
    logic                       rd_en;
    logic [SP_W-1:0]            rd_addr;
    logic [CNT_W-1:0]           count_dec;

    logic [DIGIT_W-1:0]         step_rem;
    logic [BITS_PER_CYCLE-1:0]  step_quot;
    logic [DIGIT_W:0]           step_acc;
    logic [PAD_W-1:0]           step_work;

    assign item_ready = (state_reg == BK_IDLE);
    assign out_valid  = out_valid_reg;
    assign out_digit  = out_digit_reg;
    assign out_last   = out_last_reg;
    assign count_dec  = count_reg - CNT_W'(1);

    // long division of the top byte of the work word by the radix
    always_comb
    begin
        step_rem  = rem_reg;
        step_quot = '0;
        step_acc  = '0;
        for (int i = 0; i < BITS_PER_CYCLE; i++)
        begin
            step_acc = {step_rem, work_reg[PAD_W-1-i]};
            if (step_acc >= radix)
            begin
                step_acc = step_acc - radix;
                step_quot[BITS_PER_CYCLE-1-i] = 1'b1;
            end
            step_rem = step_acc[DIGIT_W-1:0];
        end
        step_work = (work_reg << BITS_PER_CYCLE) | PAD_W'(step_quot);
    end

    // sequencer: divide and push, then pop most significant first
    always_comb
    begin
        state_next     = state_reg;
        work_next      = work_reg;
        rem_next       = rem_reg;
        chunk_next     = chunk_reg;
        count_next     = count_reg;
        out_valid_next = out_valid_reg;
        out_digit_next = out_digit_reg;
        out_last_next  = out_last_reg;
        wr_en          = 1'b0;
        wr_addr        = count_reg[SP_W-1:0];
        wr_data        = step_rem;
        rd_en          = 1'b0;
        rd_addr        = count_dec[SP_W-1:0];

        // output register drains independently
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            BK_IDLE:
            begin
                if (item_valid)
                begin
                    if (item_zero)
                    begin
                        wr_en      = 1'b1;
                        wr_addr    = '0;
                        wr_data    = '0;
                        count_next = CNT_W'(1);
                        state_next = BK_POP_RD;
                    end
                    else
                    begin
                        work_next  = PAD_W'(item_number);
                        rem_next   = '0;
                        chunk_next = '0;
                        count_next = '0;
                        state_next = BK_DIV;
                    end
                end
            end
            BK_DIV:
            begin
                work_next = step_work;
                if (chunk_reg == CHUNK_W'(CHUNKS - 1))
                begin
                    wr_en      = 1'b1;
                    count_next = count_reg + CNT_W'(1);
                    rem_next   = '0;
                    chunk_next = '0;
                    if (step_work == '0 || count_reg == CNT_W'(MAX_DIGITS - 1))
                    begin
                        state_next = BK_POP_RD;
                    end
                end
                else
                begin
                    rem_next   = step_rem;
                    chunk_next = chunk_reg + CHUNK_W'(1);
                end
            end
            BK_POP_RD:
            begin
                rd_en      = 1'b1;
                count_next = count_dec;
                state_next = BK_POP_LOAD;
            end
            BK_POP_LOAD:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    out_digit_next = rd_data_reg;
                    out_last_next  = (count_reg == '0);
                    state_next     = (count_reg == '0) ? BK_IDLE : BK_POP_RD;
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            chunk_reg     <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            chunk_reg     <= chunk_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        work_reg      <= work_next;
        rem_reg       <= rem_next;
        out_digit_reg <= out_digit_next;
        out_last_reg  <= out_last_next;
    end

    // digit stack memory
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            stack_mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= stack_mem[rd_addr];
        end
    end

endmodule

[src/radix_digit_converter_unit.sv]
// The digits of a nonzero input beat come from a long division of the number by the
// radix, done byte by byte, and are pushed on a stack; they are then popped most significant
// first, each through BK_POP_RD and BK_POP_LOAD. A zero skips the division and its single
// digit is popped the same way. The back end takes one number at a time, a new one only
// after the last digit is loaded; a two-entry input queue takes new numbers meanwhile.
// Reset: rst_n is asynchronous and active low; it empties the queue and the output
// register and sets the radix to 10.
module radix_digit_converter_unit
    import rdc_pkg::*;
#(
    parameter int NUMBER_WIDTH = DEFAULT_NUMBER_WIDTH,
    parameter int MAX_DIGITS   = DEFAULT_MAX_DIGITS
)
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    // radix write channel
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [RADIX_W-1:0]                    cfg_data,
    // input stream
    input  logic                                  s_axis_tvalid,
    output logic                                  s_axis_tready,
    input  logic [((NUMBER_WIDTH+7)/8)*8-1:0]     s_axis_tdata,   // number
    // output stream
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    output logic [7:0]                            m_axis_tdata,   // digit, zero pad
    output logic                                  m_axis_tlast
);

    logic [RADIX_W-1:0]      radix_reg;
    logic [RADIX_W-1:0]      radix_next;
    logic                    item_valid;
    logic                    item_ready;
    logic [NUMBER_WIDTH-1:0] item_number;
    logic                    item_zero;
    logic [DIGIT_W-1:0]      digit;

    // radix register with clamping
    assign cfg_ready = 1'b1;

    always_comb
    begin
        radix_next = radix_reg;
        if (cfg_valid)
        begin
            if (cfg_data < RADIX_MIN)
            begin
                radix_next = RADIX_MIN;
            end
            else if (cfg_data > RADIX_MAX)
            begin
                radix_next = RADIX_MAX;
            end
            else
            begin
                radix_next = cfg_data;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radix_reg <= RADIX_RESET;
        end
        else
        begin
            radix_reg <= radix_next;
        end
    end

    // front end: accept and classify
    rdc_front #(
        .NUMBER_WIDTH (NUMBER_WIDTH)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (s_axis_tvalid),
        .in_ready    (s_axis_tready),
        .in_number   (s_axis_tdata[NUMBER_WIDTH-1:0]),
        .item_valid  (item_valid),
        .item_ready  (item_ready),
        .item_number (item_number),
        .item_zero   (item_zero)
    );

    // back end: divide, stack and emit digits
    rdc_back #(
        .NUMBER_WIDTH (NUMBER_WIDTH),
        .MAX_DIGITS   (MAX_DIGITS)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .radix       (radix_reg),
        .item_valid  (item_valid),
        .item_ready  (item_ready),
        .item_number (item_number),
        .item_zero   (item_zero),
        .out_valid   (m_axis_tvalid),
        .out_ready   (m_axis_tready),
        .out_digit   (digit),
        .out_last    (m_axis_tlast)
    );

    assign m_axis_tdata = {{(8-DIGIT_W){1'b0}}, digit};

endmodule

[tb/radix_digit_checker.sv]
`timescale 1ns / 1ps

module radix_digit_checker
    import rdc_pkg::*;
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_valid,
    input  logic                            cfg_ready,
    input  logic [RADIX_W-1:0]              cfg_data,
    input  logic                            s_axis_tvalid,
    input  logic                            s_axis_tready,
    input  logic [DEFAULT_NUMBER_WIDTH-1:0] s_axis_tdata,   // number
    input  logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    input  logic [7:0]                      m_axis_tdata,   // digit, zero pad
    input  logic                            m_axis_tlast,
    output int                              mismatch_count,
    output int                              digits_pending
);

    typedef struct packed {
        logic [DIGIT_W-1:0] digit;
        logic               last;
    } digit_beat_t;

    logic [RADIX_W-1:0] radix_model;
    digit_beat_t        digit_q[$];
    int                 fail_total = 0;

    assign mismatch_count = fail_total;

    // divide down, stack the remainders, then queue them most significant first
    function automatic void push_digits(input logic [DEFAULT_NUMBER_WIDTH-1:0] value,
                                        input logic [RADIX_W-1:0] base);
        logic [DIGIT_W-1:0]              rem_stack[DEFAULT_MAX_DIGITS];
        logic [DEFAULT_NUMBER_WIDTH-1:0] quotient;
        int                              count;
        digit_beat_t                     beat;
        quotient = value;
        count = 0;
        // zero still gives one digit
        do
        begin
            rem_stack[count] = DIGIT_W'(quotient % base);
            count++;
            quotient = quotient / base;
        end
        while (quotient != 0 && count < DEFAULT_MAX_DIGITS);
        while (count > 0)
        begin
            count--;
            beat.digit = rem_stack[count];
            beat.last  = (count == 0);
            digit_q.push_back(beat);
        end
    endfunction

    // watch the radix writes, the number beats and the digit beats
    always @(posedge clk or negedge rst_n)
    begin
        digit_beat_t want;
        if (!rst_n)
        begin
            radix_model = RADIX_RESET;
            digit_q.delete();
            digits_pending <= 0;
        end
        else
        begin
            // radix write, clamped into the legal range
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_data < RADIX_MIN)
                    radix_model = RADIX_MIN;
                else if (cfg_data > RADIX_MAX)
                    radix_model = RADIX_MAX;
                else
                    radix_model = cfg_data;
            end

            if (s_axis_tvalid && s_axis_tready)
                push_digits(s_axis_tdata, radix_model);

            // compare each digit beat against the oldest expected digit
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (digit_q.size() == 0)
                begin
                    fail_total++;
                    $display("%0t: unexpected digit beat: expected none, actual tdata %0h tlast %0b",
                             $time, m_axis_tdata, m_axis_tlast);
                end
                else
                begin
                    want = digit_q.pop_front();
                    if (m_axis_tdata !== 8'(want.digit))
                    begin
                        fail_total++;
                        $display("%0t: tdata mismatch: expected %0h, actual %0h",
                                 $time, 8'(want.digit), m_axis_tdata);
                    end
                    if (m_axis_tlast !== want.last)
                    begin
                        fail_total++;
                        $display("%0t: tlast mismatch: expected %0b, actual %0b",
                                 $time, want.last, m_axis_tlast);
                    end
                end
            end

            digits_pending <= digit_q.size();
        end
    end

endmodule

[tb/radix_digit_converter_unit_tb.sv]
`timescale 1ns / 1ps

module radix_digit_converter_unit_tb;
    import rdc_pkg::*;

    localparam int NUM_W        = DEFAULT_NUMBER_WIDTH;
    localparam int HOLD_CYCLES  = 300;
    localparam int STALL_LIMIT  = 4000;
    localparam int DRAIN_CYCLES = 200;
    localparam int PHASES       = 8;
    localparam int PHASE_ITEMS  = 47;
    localparam int IDLE_MODES   = 4;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              cfg_valid = 1'b0;
    logic              cfg_ready;
    logic [RADIX_W-1:0] cfg_data = '0;
    logic              s_axis_tvalid = 1'b0;
    logic              s_axis_tready;
    logic [NUM_W-1:0]  s_axis_tdata = '0;   // number
    logic              m_axis_tvalid;
    logic              m_axis_tready = 1'b0;
    logic [7:0]        m_axis_tdata;        // digit, zero pad
    logic              m_axis_tlast;

    int   send_idle_pct = 0;
    int   recv_stall_pct = 0;
    logic hold_req = 1'b0;
    logic hold_ack = 1'b0;
    int   hold_left = 0;
    int   idle_cycles = 0;
    int   mismatch_count;
    int   digits_pending;

    // 10 ns clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    radix_digit_converter_unit u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    radix_digit_checker u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_data       (cfg_data),
        .s_axis_tvalid  (s_axis_tvalid),
        .s_axis_tready  (s_axis_tready),
        .s_axis_tdata   (s_axis_tdata),
        .m_axis_tvalid  (m_axis_tvalid),
        .m_axis_tready  (m_axis_tready),
        .m_axis_tdata   (m_axis_tdata),
        .m_axis_tlast   (m_axis_tlast),
        .mismatch_count (mismatch_count),
        .digits_pending (digits_pending)
    );

    // digit receiver: random stalls, or a long hold-off on request
    always @(posedge clk)
    begin
        if (hold_left > 0)
        begin
            m_axis_tready <= 1'b0;
            hold_left <= hold_left - 1;
        end
        else if (hold_req != hold_ack)
        begin
            hold_ack <= hold_req;
            hold_left <= HOLD_CYCLES;
            m_axis_tready <= 1'b0;
        end
        else
            m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // watchdog on cycles with no beat on any channel
    always @(posedge clk)
    begin
        if (!rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
            || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else if (idle_cycles >= STALL_LIMIT)
        begin
            $display("%0t: no beat for %0d cycles", $time, STALL_LIMIT);
            $display("*** FAILED ***");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    task automatic set_idling(input int mode);
        case (mode)
            0:
            begin
                send_idle_pct <= 0;
                recv_stall_pct <= 0;
            end
            1:
            begin
                send_idle_pct <= 58;
                recv_stall_pct <= 0;
            end
            2:
            begin
                send_idle_pct <= 0;
                recv_stall_pct <= 58;
            end
            default:
            begin
                send_idle_pct <= 22;
                recv_stall_pct <= 22;
            end
        endcase
    endtask

    // offer one number, after a random gap, and wait for its beat
    task automatic send_number(input logic [NUM_W-1:0] value);
        int gap;
        gap = 0;
        while ($urandom_range(99) < send_idle_pct)
            gap++;
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= value;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
    endtask

    // stop sending until every expected digit is out
    task automatic wait_for_digits;
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (digits_pending != 0)
            @(posedge clk);
    endtask

    task automatic write_radix(input logic [RADIX_W-1:0] value);
        wait_for_digits();
        cfg_valid <= 1'b1;
        cfg_data <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
    endtask

    initial
    begin
        logic [NUM_W-1:0]   value;
        logic [RADIX_W-1:0] base;
        int                 pick;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // radix ten out of reset
        send_number(32'd0);
        send_number(32'd9);
        send_number(32'd10);
        send_number(32'hFFFF_FFFF);
        send_number(32'h8000_0000);

        // radix below range clamps to two, all ones gives the most digits
        write_radix(5'd0);
        send_number(32'hFFFF_FFFF);
        send_number(32'd1);
        write_radix(5'd1);
        send_number(32'h8000_0001);

        // radix above range clamps to sixteen
        write_radix(5'd17);
        send_number(32'hFFFF_FFFF);
        send_number(32'hFEDC_BA98);
        write_radix(5'd31);
        send_number(32'd0);
        write_radix(RADIX_MAX);
        send_number(32'd15);
        send_number(32'd16);
        write_radix(5'd3);
        send_number(32'hFFFF_FFFF);
        write_radix(RADIX_MIN);
        send_number(32'd0);

        // long receiver hold-off while numbers keep coming, input must back up
        set_idling(0);
        hold_req <= ~hold_req;
        repeat (12) send_number($urandom());
        wait_for_digits();

        // random phases over radix settings and idling patterns
        for (int phase = 0; phase < PHASES; phase++)
        begin
            case (phase)
                0: base = RADIX_MIN;
                1: base = RADIX_MAX;
                default: base = RADIX_W'($urandom_range(31));
            endcase
            write_radix(base);
            set_idling(phase % IDLE_MODES);
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                pick = $urandom_range(99);
                if (pick < 40)
                    value = $urandom();
                else if (pick < 70)
                    value = $urandom_range(255);
                else if (pick < 85)
                    value = $urandom() >> $urandom_range(31);
                else if (pick < 93)
                    value = '0;
                else
                    value = '1;
                send_number(value);
            end
        end

        wait_for_digits();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && digits_pending == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
